[src/box_filter_three_by_three_macros.svh]
// Assertion macros shared by the box filter RTL.
// Expects signals named clk and rst in the module that uses them.
`ifndef BOX_FILTER_THREE_BY_THREE_MACROS_SVH
`define BOX_FILTER_THREE_BY_THREE_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define BF3_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define BF3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/bf3_pkg.sv]
// Shared constants, register codes and helpers for the 3x3 box filter.
// No dependencies; used by bf3_queue and box_filter_three_by_three.
`default_nettype none

package bf3_pkg;

  localparam int ROW_BITS       = 16;
  localparam int COL_OUT_BITS   = 10;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int COLS_CFG_BITS  = 11;
  localparam int MIN_DIM        = 3;
  localparam int RESET_ROWS     = 1024;
  localparam int RESET_COLS     = 1024;

  // Result queue: power-of-two depth, up to three pushes per cycle.
  localparam int QUEUE_DEPTH      = 16;
  localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LEVEL_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int PUSH_LANES       = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FRAME_ROWS = 2'd0,
    CFG_FRAME_COLS = 2'd1
  } cfg_reg_t;

  function automatic logic [1:0] count3(input logic [2:0] bits);
    count3 = {1'b0, bits[0]} + {1'b0, bits[1]} + {1'b0, bits[2]};
  endfunction

endpackage

`default_nettype wire

[src/box_filter_three_by_three.sv]
// 3x3 box filter top level: line stores, window, mean-of-nine datapath, result queue.
// Depends on bf3_pkg, bf3_queue and box_filter_three_by_three_macros.svh.
//
// Usage:
//   Samples enter on the s_ group (s_tdata holds one signed sample) in row-major
//   order; results leave on the m_ group. m_tdata = value, row, col from the
//   lowest bit up; m_tlast marks the last result of a frame.
//   Interior results are the mean of the 3x3 neighborhood (ties away from zero);
//   border samples are passed through. An input at (r,c) releases (r-1,c-1),
//   at the end of a row also (r-1,last column), and in the last row its own copy.
//   Path: a released word's sample enters stage 1 at its accepting edge (line store
//   read at that edge), its window sum goes to stage 2, and the divided word goes
//   into the queue, where it raises m_tvalid. Throughput: one sample per cycle while
//   the 16-word result queue has room for the words owed by samples in flight plus
//   three for the new one; the last row of a frame and the row ends yield more words
//   than samples, so there the master side sets the rate at one word per cycle.
//   Stalls: if m_tready is low the queue fills and s_tready drops; nothing is lost.
//   Reset (rst, synchronous): frame size returns to 1024 x 1024, position to the
//   frame start, queue empties. A write of either size register also restarts
//   the frame; write it only while the block is idle.
`default_nettype none
`include "box_filter_three_by_three_macros.svh"

module box_filter_three_by_three #(
  parameter int MAX_COLS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [bf3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [bf3_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // input stream; tdata: sample
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
  // output stream; tdata: value, row, col; tlast: frame_end
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [((SAMPLE_BITS+bf3_pkg::ROW_BITS+bf3_pkg::COL_OUT_BITS+7)/8)*8-1:0] m_tdata,
  output logic                                     m_tlast
);

  localparam int B      = SAMPLE_BITS;
  localparam int CW     = $clog2(MAX_COLS);
  localparam int RW     = bf3_pkg::ROW_BITS;
  localparam int OCW    = bf3_pkg::COL_OUT_BITS;
  localparam int LW     = bf3_pkg::QUEUE_LEVEL_BITS;
  localparam int SUM_W  = B + 4;
  localparam int PROD_W = 2 * SUM_W + 1;
  localparam int Q_W    = SUM_W - 3;
  localparam int WORD_W = B + RW + OCW + 1;
  localparam int M_W    = ((B + RW + OCW + 7) / 8) * 8;
  // floor(x/9) = (x * RECIP) >> (SUM_W+4), exact for x below 2**SUM_W
  localparam logic [SUM_W:0] RECIP =
    (SUM_W+1)'(((65'd1 << (SUM_W + 4)) + 65'd8) / 65'd9);
  localparam logic [CW-1:0] LAST_COL_RST =
    CW'(((MAX_COLS < bf3_pkg::RESET_COLS) ? MAX_COLS : bf3_pkg::RESET_COLS) - 1);

  // frame geometry, stored as last index
  logic [RW-1:0]  last_row;
  logic [CW-1:0]  last_col;
  logic [RW-1:0]  last_row_next;
  logic [31:0]    last_col_wide;
  logic           cfg_hit;

  // position of the next input
  logic [RW-1:0]  row_count;
  logic [CW-1:0]  col_count;

  logic           accept;
  logic [B-1:0]   sample;
  logic [2:0]     has;

  // line stores
  logic signed [B-1:0] line_prev  [MAX_COLS];
  logic signed [B-1:0] line_prev2 [MAX_COLS];
  logic signed [B-1:0] rd_prev;
  logic signed [B-1:0] rd_prev2;

  // stage 1: sample and position, line store words arrive
  logic                s1_valid;
  logic [2:0]          s1_has;
  logic signed [B-1:0] s1_sample;
  logic [RW-1:0]       s1_row;
  logic [CW-1:0]       s1_col;
  logic                s1_rg1;
  logic                s1_rg2;
  logic                s1_border;
  logic                s1_clast;

  logic signed [B-1:0] window_left [3];
  logic signed [B-1:0] window_mid  [3];
  logic signed [B-1:0] fresh [3];
  logic signed [SUM_W-1:0] sum;

  // stage 2: sum ready, divide and build result words
  logic [2:0]              s2_has;
  logic signed [SUM_W-1:0] s2_sum;
  logic signed [B-1:0]     s2_pass;
  logic signed [B-1:0]     s2_fresh1;
  logic signed [B-1:0]     s2_sample;
  logic [RW-1:0]           s2_row;
  logic [CW-1:0]           s2_col;
  logic                    s2_border;
  logic                    s2_clast;

  logic              neg;
  logic [SUM_W-1:0]  mag;
  logic [SUM_W-1:0]  rounded;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    quot;
  logic [Q_W-1:0]    quot_signed;
  logic [B-1:0]      mean;
  logic [B-1:0]      lane0_value;
  logic [RW-1:0]     row_m1;
  logic [CW-1:0]     col_m1;
  logic [31:0]       col_wide;
  logic [31:0]       col_m1_wide;

  logic [WORD_W-1:0] push_data [bf3_pkg::PUSH_LANES];
  logic [WORD_W-1:0] pop_data;
  logic [LW-1:0]     level;
  logic [LW+1:0]     reserved;

  // ---------------------------------------------------------------- config
  assign cfg_hit = cfg_we && (cfg_index == bf3_pkg::CFG_FRAME_ROWS ||
                              cfg_index == bf3_pkg::CFG_FRAME_COLS);

  // sizes below three act as three; columns clamp to the line store depth
  always_comb begin
    if (cfg_data < RW'(bf3_pkg::MIN_DIM)) begin
      last_row_next = RW'(bf3_pkg::MIN_DIM - 1);
    end else begin
      last_row_next = cfg_data - RW'(1);
    end
    if (32'(cfg_data[bf3_pkg::COLS_CFG_BITS-1:0]) < 32'(bf3_pkg::MIN_DIM)) begin
      last_col_wide = 32'(bf3_pkg::MIN_DIM - 1);
    end else if (32'(cfg_data[bf3_pkg::COLS_CFG_BITS-1:0]) > 32'(MAX_COLS)) begin
      last_col_wide = 32'(MAX_COLS - 1);
    end else begin
      last_col_wide = 32'(cfg_data[bf3_pkg::COLS_CFG_BITS-1:0]) - 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_row <= RW'(bf3_pkg::RESET_ROWS - 1);
      last_col <= LAST_COL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bf3_pkg::CFG_FRAME_ROWS: last_row <= last_row_next;
        bf3_pkg::CFG_FRAME_COLS: last_col <= last_col_wide[CW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input side
  // Room for every word already owed plus the worst case of a new sample.
  assign reserved = (LW+2)'(level) + (LW+2)'(bf3_pkg::count3(s1_has)) +
                    (LW+2)'(bf3_pkg::count3(s2_has));
  assign s_tready = !rst &&
    (reserved + (LW+2)'(bf3_pkg::PUSH_LANES) <= (LW+2)'(bf3_pkg::QUEUE_DEPTH));
  assign accept   = s_tvalid && s_tready;
  assign sample   = s_tdata[B-1:0];

  // words this sample releases: mean/top or left border, right border, last row copy
  always_comb begin
    has[0] = (row_count != '0) && (col_count != '0);
    has[1] = (row_count != '0) && (col_count == last_col);
    has[2] = (row_count == last_row);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (col_count == last_col) begin
        col_count <= '0;
        row_count <= (row_count == last_row) ? '0 : row_count + RW'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // line stores: read at accept, rotated from the stage 1 registers (different column)
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_prev  <= line_prev[col_count];
      rd_prev2 <= line_prev2[col_count];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_prev[s1_col]  <= s1_sample;
      line_prev2[s1_col] <= rd_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_has   <= '0;
    end else begin
      s1_valid <= accept;
      s1_has   <= accept ? has : 3'b000;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= $signed(sample);
      s1_row    <= row_count;
      s1_col    <= col_count;
      s1_rg1    <= (row_count != '0);
      s1_rg2    <= (row_count[RW-1:1] != '0);
      s1_border <= (row_count == RW'(1)) || (col_count == CW'(1));
      s1_clast  <= (col_count == last_col);
    end
  end

  // ---------------------------------------------------------------- window sum
  always_comb begin
    fresh[0] = s1_rg2 ? rd_prev2 : '0;
    fresh[1] = s1_rg1 ? rd_prev : '0;
    fresh[2] = s1_sample;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      sum = sum + SUM_W'(window_left[i]) + SUM_W'(window_mid[i]) + SUM_W'(fresh[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        window_left[i] <= '0;
        window_mid[i]  <= '0;
      end
    end else if (s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        window_left[i] <= window_mid[i];
        window_mid[i]  <= fresh[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_has <= '0;
    end else begin
      s2_has <= s1_valid ? s1_has : 3'b000;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_sum    <= sum;
      s2_pass   <= window_mid[1];  // center of the window, for a left or top border
      s2_fresh1 <= fresh[1];
      s2_sample <= s1_sample;
      s2_row    <= s1_row;
      s2_col    <= s1_col;
      s2_border <= s1_border;
      s2_clast  <= s1_clast;
    end
  end

  // ---------------------------------------------------------------- divide by nine
  // round half away from zero: floor((|sum| + 4) / 9), sign restored
  always_comb begin
    neg         = s2_sum[SUM_W-1];
    mag         = neg ? $unsigned(-s2_sum) : $unsigned(s2_sum);
    rounded     = mag + SUM_W'(4);
    prod        = PROD_W'(rounded) * PROD_W'(RECIP);
    quot        = prod[PROD_W-1 -: Q_W];
    quot_signed = neg ? (~quot + Q_W'(1)) : quot;
    mean        = quot_signed[B-1:0];
    lane0_value = s2_border ? s2_pass : mean;
  end

  // ---------------------------------------------------------------- result words
  always_comb begin
    row_m1      = s2_row - RW'(1);
    col_m1      = s2_col - CW'(1);
    col_wide    = 32'(s2_col);
    col_m1_wide = 32'(col_m1);
    push_data[0] = {1'b0, col_m1_wide[OCW-1:0], row_m1, lane0_value};
    push_data[1] = {1'b0, col_wide[OCW-1:0], row_m1, s2_fresh1};
    push_data[2] = {s2_clast, col_wide[OCW-1:0], s2_row, s2_sample};
  end

  bf3_queue #(
    .WIDTH (WORD_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s2_has),
    .push_data  (push_data),
    .pop_valid  (m_tvalid),
    .pop_ready  (m_tready),
    .pop_data   (pop_data),
    .level      (level)
  );

  assign m_tdata = M_W'(pop_data[WORD_W-2:0]);
  assign m_tlast = pop_data[WORD_W-1];

  // ---------------------------------------------------------------- checks
  `BF3_ASSERT_ALWAYS(a_queue_reserve, reserved <= (LW+2)'(bf3_pkg::QUEUE_DEPTH), "result words owed exceed queue depth")
  `BF3_ASSERT_NEXT(a_row_wrap, accept && col_count == last_col, col_count == '0, "column count did not wrap at row end")
  `BF3_ASSERT_NEXT(a_cfg_restart, cfg_hit, row_count == '0 && col_count == '0, "size write did not restart the frame")

endmodule

`default_nettype wire

[src/bf3_queue.sv]
// Result queue of the box filter: up to three words in, one word out per cycle while pop_ready is high.
// Depends on bf3_pkg and box_filter_three_by_three_macros.svh.
`default_nettype none
`include "box_filter_three_by_three_macros.svh"

module bf3_queue #(
  parameter int WIDTH = 43
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [bf3_pkg::PUSH_LANES-1:0]        push_valid,
  input  wire logic [WIDTH-1:0]                      push_data [bf3_pkg::PUSH_LANES],
  output logic                                       pop_valid,
  input  wire logic                                  pop_ready,
  output logic [WIDTH-1:0]                           pop_data,
  output logic [bf3_pkg::QUEUE_LEVEL_BITS-1:0]       level
);

  localparam int PW = bf3_pkg::QUEUE_PTR_BITS;
  localparam int LW = bf3_pkg::QUEUE_LEVEL_BITS;

  logic [WIDTH-1:0] mem [bf3_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW-1:0]    lane_addr [bf3_pkg::PUSH_LANES];
  logic [LW-1:0]    push_count;
  logic [LW-1:0]    pop_count;
  logic             pop;

  // valid lanes pack densely, in lane order
  always_comb begin
    lane_addr[0] = wr_ptr;
    lane_addr[1] = wr_ptr + PW'(push_valid[0]);
    lane_addr[2] = wr_ptr + PW'(push_valid[0]) + PW'(push_valid[1]);
  end

  assign push_count = LW'(bf3_pkg::count3(push_valid));
  assign pop_valid  = (level != '0);
  assign pop        = pop_valid && pop_ready;
  assign pop_count  = LW'(pop);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    for (int j = 0; j < bf3_pkg::PUSH_LANES; j++) begin
      if (push_valid[j]) begin
        mem[lane_addr[j]] <= push_data[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_count);
      rd_ptr <= rd_ptr + PW'(pop_count);
      level  <= level + push_count - pop_count;
    end
  end

  `BF3_ASSERT_ALWAYS(a_level_bound, level <= LW'(bf3_pkg::QUEUE_DEPTH), "queue level above depth")
  `BF3_ASSERT_NEXT(a_level_track, 1'b1, level == $past(level) + $past(push_count) - $past(pop_count), "queue level mismatch")
  `BF3_ASSERT_ALWAYS(a_no_overflow, (LW+1)'(level) + (LW+1)'(push_count) <= (LW+1)'(bf3_pkg::QUEUE_DEPTH) + (LW+1)'(pop_count), "queue push overflow")

endmodule

`default_nettype wire
